>>> sv/prfl_pkg.sv
// shared types, codes and defaults for the port reservation free list
package prfl_pkg;

   localparam int MAX_PORTS_DEF = 16;
   localparam int FUNC_W = 2;
   localparam int ID_W = 4;
   localparam int RES_W = 4;
   localparam int ST_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_REGISTER = 2'd0,
      FUNC_RESERVE  = 2'd1,
      FUNC_RELEASE  = 2'd2,
      FUNC_TAKE     = 2'd3
   } func_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_UNREG = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_TAKE_WAIT,
      S_RSV_CHK,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic do_register;
      logic set_full;
      logic set_unreg;
      logic do_release;
      logic set_none;
      logic rd_head;
      logic take_target;
      logic id_target;
      logic mark;
      logic ptr_init;
      logic rd_ptr;
      logic ptr_dec;
      logic rd_next;
      logic shift_wr;
      logic count_dec;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     unreg;
      logic     full;
      logic     empty;
      logic     flag_id;
      logic     flag_target;
      logic     match;
      logic     ptr_zero;
      logic     shift_end;
   } stat_type;

endpackage

>>> sv/port_reservation_free_list_top.sv
// one word at a time: register, release, errors and an empty take go from accept through the
// execute state straight to the result word; a reserve of a reserved port or to an empty list
// adds the reserve check, and any other reserve adds a search from the head down and a move of
// each entry above the match; a take reads the head and pops it through the same walk
// the next word is accepted the cycle after the result is taken
// reset: counters and reserve flags clear at once; list memory contents stay undefined
module port_reservation_free_list_top #(
   parameter int MaxPorts = prfl_pkg::MAX_PORTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // func[1:0], port_id[5:2], zero[7:6]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // result_index[3:0], status[5:4], zero[7:6]
);

   prfl_pkg::cmd_type               cmd;
   prfl_pkg::stat_type              stat;
   logic [prfl_pkg::RES_W-1:0]      result_index;
   prfl_pkg::status_type            status;

   prfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   prfl_dp #(
      .MaxPorts (MaxPorts)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .func         (prfl_pkg::func_type'(req_tdata[1:0])),
      .port_id      (req_tdata[5:2]),
      .cmd          (cmd),
      .stat         (stat),
      .result_index (result_index),
      .status       (status)
   );

   assign rsp_tdata = {2'b00, status, result_index};

endmodule

>>> sv/prfl_dp.sv
// datapath: free list memory, reserve flags, counters and result registers
module prfl_dp #(
   parameter int MaxPorts = prfl_pkg::MAX_PORTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  prfl_pkg::func_type             func,
   input  logic [prfl_pkg::ID_W-1:0]      port_id,
   input  prfl_pkg::cmd_type              cmd,
   output prfl_pkg::stat_type             stat,
   output logic [prfl_pkg::RES_W-1:0]     result_index,
   output prfl_pkg::status_type           status
);

   localparam int IdxW = $clog2(MaxPorts);
   localparam int CntW = $clog2(MaxPorts + 1);
   localparam int CmpW = (CntW > prfl_pkg::ID_W) ? CntW : prfl_pkg::ID_W;
   localparam int ExtW = (IdxW > prfl_pkg::RES_W) ? IdxW : prfl_pkg::RES_W;

   logic [IdxW-1:0] mem [MaxPorts];

   prfl_pkg::func_type          func_ff, func_in;
   logic [prfl_pkg::ID_W-1:0]   id_ff, id_in;
   logic [IdxW-1:0]             target_ff, target_in;
   logic [IdxW-1:0]             ptr_ff, ptr_in;
   logic [IdxW-1:0]             rd_data_ff;
   logic [CntW-1:0]             free_count_ff, free_count_in;
   logic [CntW-1:0]             reg_count_ff, reg_count_in;
   logic [MaxPorts-1:0]         flags_ff, flags_in;
   logic [prfl_pkg::RES_W-1:0]  result_ff, result_in;
   prfl_pkg::status_type        status_ff, status_in;

   logic [CmpW-1:0] id_ext, reg_ext;
   logic [IdxW-1:0] id_idx, reg_idx, head_addr, push_val, waddr, wdata, raddr;
   logic [ExtW-1:0] reg_wide, rd_wide;
   logic            push, can_push, we, re;

   assign id_ext    = CmpW'(id_ff);
   assign reg_ext   = CmpW'(reg_count_ff);
   assign id_idx    = id_ext[IdxW-1:0];
   assign reg_idx   = reg_count_ff[IdxW-1:0];
   assign head_addr = IdxW'(free_count_ff - CntW'(1));
   assign reg_wide  = ExtW'(reg_idx);
   assign rd_wide   = ExtW'(rd_data_ff);

   always_comb begin
      stat.func        = func_ff;
      stat.unreg       = (id_ext >= reg_ext);
      stat.full        = (reg_count_ff == CntW'(MaxPorts));
      stat.empty       = (free_count_ff == '0);
      stat.flag_id     = flags_ff[id_idx];
      stat.flag_target = flags_ff[target_ff];
      stat.match       = (rd_data_ff == target_ff);
      stat.ptr_zero    = (ptr_ff == '0);
      stat.shift_end   = ((CntW'(ptr_ff) + CntW'(1)) >= free_count_ff);
   end

   // head push for register and release, entry move for the compaction walk
   assign push     = cmd.do_register | cmd.do_release;
   assign push_val = cmd.do_register ? reg_idx : id_idx;
   assign can_push = (free_count_ff < CntW'(MaxPorts));
   assign we       = (push & can_push) | cmd.shift_wr;
   assign waddr    = cmd.shift_wr ? ptr_ff : free_count_ff[IdxW-1:0];
   assign wdata    = cmd.shift_wr ? rd_data_ff : push_val;
   assign re       = cmd.rd_head | cmd.rd_ptr | cmd.rd_next;

   always_comb begin
      priority if (cmd.rd_head) begin
         raddr = head_addr;
      end else if (cmd.rd_next) begin
         raddr = ptr_ff + IdxW'(1);
      end else begin
         raddr = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_comb begin
      func_in       = cmd.load ? func : func_ff;
      id_in         = cmd.load ? port_id : id_ff;
      free_count_in = free_count_ff;
      if (push && can_push) begin
         free_count_in = free_count_ff + CntW'(1);
      end else if (cmd.count_dec) begin
         free_count_in = free_count_ff - CntW'(1);
      end
      reg_count_in = cmd.do_register ? reg_count_ff + CntW'(1) : reg_count_ff;

      flags_in = flags_ff;
      if (cmd.do_register) begin
         flags_in[reg_idx] = 1'b0;
      end
      if (cmd.do_release) begin
         flags_in[id_idx] = 1'b0;
      end
      if (cmd.mark) begin
         flags_in[target_ff] = 1'b1;
      end

      target_in = target_ff;
      if (cmd.id_target) begin
         target_in = id_idx;
      end else if (cmd.take_target) begin
         target_in = rd_data_ff;
      end

      ptr_in = ptr_ff;
      if (cmd.ptr_init) begin
         ptr_in = head_addr;
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - IdxW'(1);
      end else if (cmd.shift_wr) begin
         ptr_in = ptr_ff + IdxW'(1);
      end

      result_in = result_ff;
      if (cmd.load) begin
         result_in = '0;
      end else if (cmd.do_register) begin
         result_in = reg_wide[prfl_pkg::RES_W-1:0];
      end else if (cmd.take_target) begin
         result_in = rd_wide[prfl_pkg::RES_W-1:0];
      end

      status_in = status_ff;
      if (cmd.load) begin
         status_in = prfl_pkg::ST_OK;
      end else if (cmd.set_full) begin
         status_in = prfl_pkg::ST_FULL;
      end else if (cmd.set_unreg) begin
         status_in = prfl_pkg::ST_UNREG;
      end else if (cmd.set_none) begin
         status_in = prfl_pkg::ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         reg_count_ff  <= '0;
         flags_ff      <= '0;
      end else begin
         free_count_ff <= free_count_in;
         reg_count_ff  <= reg_count_in;
         flags_ff      <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      id_ff     <= id_in;
      target_ff <= target_in;
      ptr_ff    <= ptr_in;
      result_ff <= result_in;
      status_ff <= status_in;
   end

   assign result_index = result_ff;
   assign status       = status_ff;

endmodule

>>> sv/prfl_ctrl.sv
// controller: sequences one word at a time through decode, search and compaction
module prfl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  prfl_pkg::stat_type  stat,
   output prfl_pkg::cmd_type   cmd
);

   prfl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prfl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prfl_pkg::S_IDLE: begin
            if (req_tvalid) state_in = prfl_pkg::S_EXEC;
         end
         prfl_pkg::S_EXEC: begin
            unique case (stat.func)
               prfl_pkg::FUNC_REGISTER: state_in = prfl_pkg::S_DONE;
               prfl_pkg::FUNC_RELEASE:  state_in = prfl_pkg::S_DONE;
               prfl_pkg::FUNC_RESERVE: begin
                  state_in = stat.unreg ? prfl_pkg::S_DONE : prfl_pkg::S_RSV_CHK;
               end
               prfl_pkg::FUNC_TAKE: begin
                  state_in = stat.empty ? prfl_pkg::S_DONE : prfl_pkg::S_TAKE_WAIT;
               end
            endcase
         end
         prfl_pkg::S_TAKE_WAIT: state_in = prfl_pkg::S_RSV_CHK;
         prfl_pkg::S_RSV_CHK: begin
            if (stat.flag_target || stat.empty) begin
               state_in = prfl_pkg::S_DONE;
            end else begin
               state_in = prfl_pkg::S_SRCH_RD;
            end
         end
         prfl_pkg::S_SRCH_RD: state_in = prfl_pkg::S_SRCH_CMP;
         prfl_pkg::S_SRCH_CMP: begin
            priority if (stat.match) begin
               state_in = prfl_pkg::S_SHIFT_RD;
            end else if (stat.ptr_zero) begin
               state_in = prfl_pkg::S_DONE;
            end else begin
               state_in = prfl_pkg::S_SRCH_RD;
            end
         end
         prfl_pkg::S_SHIFT_RD: begin
            state_in = stat.shift_end ? prfl_pkg::S_DONE : prfl_pkg::S_SHIFT_WR;
         end
         prfl_pkg::S_SHIFT_WR: state_in = prfl_pkg::S_SHIFT_RD;
         prfl_pkg::S_DONE: begin
            if (rsp_tready) state_in = prfl_pkg::S_IDLE;
         end
         default: state_in = prfl_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         prfl_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         prfl_pkg::S_EXEC: begin
            unique case (stat.func)
               prfl_pkg::FUNC_REGISTER: begin
                  cmd.set_full    = stat.full;
                  cmd.do_register = !stat.full;
               end
               prfl_pkg::FUNC_RESERVE: begin
                  cmd.set_unreg = stat.unreg;
                  cmd.id_target = !stat.unreg;
               end
               prfl_pkg::FUNC_RELEASE: begin
                  cmd.set_unreg  = stat.unreg;
                  cmd.do_release = !stat.unreg && stat.flag_id;
               end
               prfl_pkg::FUNC_TAKE: begin
                  cmd.set_none = stat.empty;
                  cmd.rd_head  = !stat.empty;
               end
            endcase
         end
         prfl_pkg::S_TAKE_WAIT: cmd.take_target = 1'b1;
         prfl_pkg::S_RSV_CHK: begin
            cmd.mark     = !stat.flag_target;
            cmd.ptr_init = !stat.flag_target;
         end
         prfl_pkg::S_SRCH_RD: cmd.rd_ptr = 1'b1;
         prfl_pkg::S_SRCH_CMP: begin
            cmd.ptr_dec = !stat.match && !stat.ptr_zero;
         end
         prfl_pkg::S_SHIFT_RD: begin
            cmd.count_dec = stat.shift_end;
            cmd.rd_next   = !stat.shift_end;
         end
         prfl_pkg::S_SHIFT_WR: cmd.shift_wr = 1'b1;
         prfl_pkg::S_DONE: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

>>> tb/tb_top.sv
// testbench for the port reservation free list: directed table, weighted random ops, self-check
`timescale 1ns / 1ps

module tb_top;

   localparam int PORTS = prfl_pkg::MAX_PORTS_DEF;
   localparam int DRAIN_CYCLES = 80;   // worst search plus compaction at a full list
   localparam int DRAIN_LIMIT = 20000;

   typedef struct packed {
      prfl_pkg::func_type   op;
      logic [3:0]           id;
      logic                 typed;
      logic [3:0]           idx;
      prfl_pkg::status_type st;
   } dir_row_type;

   typedef struct packed {
      logic [3:0]           idx;
      prfl_pkg::status_type st;
   } answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // func[1:0], port_id[5:2], zero[7:6]
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // result_index[3:0], status[5:4], zero[7:6]

   logic       hold_req = 1'b0;
   bit         hold_go = 1'b0;
   int         stall_pct = 0;
   int         send_idle_pct = 0;
   int         errors = 0;
   int         words_sent = 0;
   int         st_seen [4] = '{0, 0, 0, 0};

   // allocator state mirrored by the predictor
   logic [3:0] fl_order [PORTS];
   int         fl_count = 0;
   bit         port_rsv [PORTS];
   int         port_cnt = 0;

   answer_type  answer_q [$];
   dir_row_type dir_rows [25];

   port_reservation_free_list_top #(.MaxPorts(PORTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // mark a port reserved and drop it from the list, searching from the head down
   task automatic claim_port(input logic [3:0] p);
      int pos;
      int k;
      if (port_rsv[p]) begin
         return;
      end
      port_rsv[p] = 1'b1;
      for (pos = fl_count - 1; pos >= 0; pos--) begin
         if (fl_order[pos] == p) begin
            for (k = pos; k + 1 < fl_count; k++) begin
               fl_order[k] = fl_order[k + 1];
            end
            fl_count--;
            return;
         end
      end
   endtask

   task automatic push_free(input logic [3:0] p);
      if (fl_count < PORTS) begin
         fl_order[fl_count] = p;
         fl_count++;
      end
   endtask

   task automatic alloc_predict(input prfl_pkg::func_type op, input logic [3:0] id,
                                output logic [3:0] idx, output prfl_pkg::status_type st);
      idx = 4'd0;
      st = prfl_pkg::ST_OK;
      case (op)
         prfl_pkg::FUNC_REGISTER: begin
            if (port_cnt >= PORTS) begin
               st = prfl_pkg::ST_FULL;
            end else begin
               idx = port_cnt[3:0];
               port_rsv[port_cnt] = 1'b0;
               port_cnt++;
               push_free(idx);
            end
         end
         prfl_pkg::FUNC_RESERVE: begin
            if (int'(id) >= port_cnt) begin
               st = prfl_pkg::ST_UNREG;
            end else begin
               claim_port(id);
            end
         end
         prfl_pkg::FUNC_RELEASE: begin
            if (int'(id) >= port_cnt) begin
               st = prfl_pkg::ST_UNREG;
            end else if (port_rsv[id]) begin
               port_rsv[id] = 1'b0;
               push_free(id);
            end
         end
         default: begin
            if (fl_count == 0) begin
               st = prfl_pkg::ST_NONE;
            end else begin
               idx = fl_order[fl_count - 1];
               claim_port(idx);
            end
         end
      endcase
   endtask

   task automatic send_word(input prfl_pkg::func_type op, input logic [3:0] id,
                            input logic typed, input logic [3:0] t_idx,
                            input prfl_pkg::status_type t_st);
      logic [3:0]           p_idx;
      prfl_pkg::status_type p_st;
      answer_type           a;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, id, op};
      do @(posedge clock); while (!req_tready);
      alloc_predict(op, id, p_idx, p_st);
      a.idx = typed ? t_idx : p_idx;
      a.st = typed ? t_st : p_st;
      answer_q.push_back(a);
      words_sent++;
   endtask

   task automatic send_random;
      int r;
      prfl_pkg::func_type op;
      logic [3:0] id;
      r = $urandom_range(99);
      if (r < ((port_cnt < PORTS) ? 3 : 2)) begin
         op = prfl_pkg::FUNC_REGISTER;
      end else if (r < 36) begin
         op = prfl_pkg::FUNC_RESERVE;
      end else if (r < 70) begin
         op = prfl_pkg::FUNC_RELEASE;
      end else begin
         op = prfl_pkg::FUNC_TAKE;
      end
      // mostly registered ids, some anything at all
      if (port_cnt > 0 && $urandom_range(9) != 0) begin
         id = 4'($urandom_range(port_cnt - 1));
      end else begin
         id = 4'($urandom_range(15));
      end
      send_word(op, id, 1'b0, 4'd0, prfl_pkg::ST_OK);
   endtask

   task automatic check_word;
      answer_type a;
      if (answer_q.size() == 0) begin
         $error("result word with no expectation: data %h", rsp_tdata);
         errors++;
         return;
      end
      a = answer_q.pop_front();
      st_seen[rsp_tdata[5:4]]++;
      if (rsp_tdata[3:0] !== a.idx) begin
         $error("result_index: expected %0d, actual %0d", a.idx, rsp_tdata[3:0]);
         errors++;
      end
      if (rsp_tdata[5:4] !== a.st) begin
         $error("status: expected %0d, actual %0d", a.st, rsp_tdata[5:4]);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_word();
         end
         if (hold_req) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_req <= 1'b1;
      repeat (200) @(posedge clock);
      hold_req <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int ph;
      int n;
      int waited;
      int ph_items [4];
      int ph_idle  [4];
      int ph_stall [4];

      ph_items = '{500, 400, 400, 500};
      ph_idle  = '{0, 71, 0, 16};
      ph_stall = '{0, 0, 71, 16};

      dir_rows = '{
         '{prfl_pkg::FUNC_TAKE,     4'd0,  1'b1, 4'd0, prfl_pkg::ST_NONE},   // empty after reset
         '{prfl_pkg::FUNC_RESERVE,  4'd0,  1'b1, 4'd0, prfl_pkg::ST_UNREG},
         '{prfl_pkg::FUNC_RELEASE,  4'd15, 1'b1, 4'd0, prfl_pkg::ST_UNREG},
         '{prfl_pkg::FUNC_REGISTER, 4'd0,  1'b1, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_REGISTER, 4'd15, 1'b1, 4'd1, prfl_pkg::ST_OK},     // id is ignored
         '{prfl_pkg::FUNC_REGISTER, 4'd0,  1'b1, 4'd2, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_REGISTER, 4'd0,  1'b1, 4'd3, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_RESERVE,  4'd4,  1'b1, 4'd0, prfl_pkg::ST_UNREG},  // first unregistered
         '{prfl_pkg::FUNC_RESERVE,  4'd1,  1'b0, 4'd0, prfl_pkg::ST_OK},     // middle of the list
         '{prfl_pkg::FUNC_RESERVE,  4'd1,  1'b0, 4'd0, prfl_pkg::ST_OK},     // already reserved
         '{prfl_pkg::FUNC_RELEASE,  4'd2,  1'b0, 4'd0, prfl_pkg::ST_OK},     // not reserved
         '{prfl_pkg::FUNC_TAKE,     4'd15, 1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_TAKE,     4'd0,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_RELEASE,  4'd1,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_TAKE,     4'd0,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_TAKE,     4'd0,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_TAKE,     4'd5,  1'b0, 4'd0, prfl_pkg::ST_OK},     // list drained again
         '{prfl_pkg::FUNC_RELEASE,  4'd3,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_RELEASE,  4'd0,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_RELEASE,  4'd2,  1'b0, 4'd0, prfl_pkg::ST_OK},
         '{prfl_pkg::FUNC_RESERVE,  4'd3,  1'b0, 4'd0, prfl_pkg::ST_OK},     // tail, longest shift
         '{prfl_pkg::FUNC_RESERVE,  4'd2,  1'b0, 4'd0, prfl_pkg::ST_OK},     // head entry
         '{prfl_pkg::FUNC_RELEASE,  4'd15, 1'b1, 4'd0, prfl_pkg::ST_UNREG},
         '{prfl_pkg::FUNC_RESERVE,  4'd10, 1'b1, 4'd0, prfl_pkg::ST_UNREG},
         '{prfl_pkg::FUNC_REGISTER, 4'd0,  1'b1, 4'd4, prfl_pkg::ST_OK}
      };
      for (n = 0; n < PORTS; n++) begin
         fl_order[n] = 4'd0;
         port_rsv[n] = 1'b0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed,
                   dir_rows[i].idx, dir_rows[i].st);
      end

      for (ph = 0; ph < 4; ph++) begin
         send_idle_pct = ph_idle[ph];
         stall_pct <= ph_stall[ph];
         for (n = 0; n < ph_items[ph]; n++) begin
            send_random();
         end
         if (ph == 0) begin
            // back-to-back words while the result side is held off
            hold_go = 1'b1;
            for (n = 0; n < 30; n++) begin
               send_random();
            end
         end
      end
      req_tvalid <= 1'b0;

      waited = 0;
      while (answer_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (answer_q.size() != 0) begin
         $error("%0d expected results never arrived", answer_q.size());
         errors++;
      end

      $display("run: %0d words over four idle/stall mixes plus a 200-cycle result hold-off",
               words_sent);
      $display("answers: ok %0d, none free %0d, unregistered %0d, table full %0d",
               st_seen[prfl_pkg::ST_OK], st_seen[prfl_pkg::ST_NONE],
               st_seen[prfl_pkg::ST_UNREG], st_seen[prfl_pkg::ST_FULL]);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
